// ===== rtl/core/pzb_pkg.sv =====
// Shared constants, the digit payload type, and the bar-table and check-digit functions for the POSTNET encoder.
`timescale 1ns / 1ps
`default_nettype none
package pzb_pkg;

  localparam int ZIP_W    = 17;
  localparam int BAR_W    = 32;
  localparam int CHECK_W  = 4;
  localparam int DIGIT_W  = 4;
  localparam int GROUP_W  = 5;
  localparam int NDIGITS  = 5;
  localparam int DIGITS_W = NDIGITS * DIGIT_W;
  localparam int SUM_W    = 6;

  localparam logic [ZIP_W-1:0] ZIP_SPAN = 17'd100000;

  // n / 10 == (n * DIV10_MUL) >> DIV10_SHIFT for every n below 2**18
  localparam logic [ZIP_W-1:0] DIV10_MUL   = 17'd104858;
  localparam int               DIV10_SHIFT = 20;
  localparam int               PROD_W      = 2 * ZIP_W;

  typedef struct packed {
    logic [ZIP_W-1:0]    rest;
    logic [DIGITS_W-1:0] digits;
    logic [SUM_W-1:0]    sum;
  } digit_bus_t;

  function automatic logic [GROUP_W-1:0] group_of(input logic [DIGIT_W-1:0] d);
    logic [GROUP_W-1:0] g;
    begin
      case (d)
        4'd0:    g = 5'b11000;
        4'd1:    g = 5'b00011;
        4'd2:    g = 5'b00101;
        4'd3:    g = 5'b00110;
        4'd4:    g = 5'b01001;
        4'd5:    g = 5'b01010;
        4'd6:    g = 5'b01100;
        4'd7:    g = 5'b10001;
        4'd8:    g = 5'b10010;
        4'd9:    g = 5'b10100;
        default: g = 5'b00000;
      endcase
      return g;
    end
  endfunction

  // (10 - sum mod 10) mod 10 for a digit sum of at most 45
  function automatic logic [CHECK_W-1:0] check_of(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    begin
      if (s >= 6'd40)      r = s - 6'd40;
      else if (s >= 6'd30) r = s - 6'd30;
      else if (s >= 6'd20) r = s - 6'd20;
      else if (s >= 6'd10) r = s - 6'd10;
      else                 r = s;
      return (r == 6'd0) ? 4'd0 : CHECK_W'(6'd10 - r);
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pzb_reduce_stage.sv =====
// Entry stage: fold the ZIP value into 0..99999 and register it.
`timescale 1ns / 1ps
`default_nettype none
module pzb_reduce_stage (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      up_valid,
  output logic                           up_stall,
  input  wire logic [pzb_pkg::ZIP_W-1:0] zip_in,
  output logic                           dn_valid,
  input  wire logic                      dn_stall,
  output pzb_pkg::digit_bus_t            dn_bus
);

  logic load;

  assign up_stall = dn_valid & dn_stall;
  assign load     = ~up_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (load) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      dn_bus.rest   <= (zip_in >= pzb_pkg::ZIP_SPAN) ? zip_in - pzb_pkg::ZIP_SPAN : zip_in;
      dn_bus.digits <= '0;
      dn_bus.sum    <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pzb_digit_stage.sv =====
// One digit stage: peel the low decimal digit off, push it into the digit list, add it to the sum.
`timescale 1ns / 1ps
`default_nettype none
module pzb_digit_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                up_valid,
  output logic                     up_stall,
  input  wire pzb_pkg::digit_bus_t up_bus,
  output logic                     dn_valid,
  input  wire logic                dn_stall,
  output pzb_pkg::digit_bus_t      dn_bus
);

  logic                               load;
  logic [pzb_pkg::PROD_W-1:0]         prod;
  logic [pzb_pkg::ZIP_W-1:0]          quot;
  logic [pzb_pkg::ZIP_W-1:0]          quot10;
  logic [pzb_pkg::ZIP_W-1:0]          low;
  logic [pzb_pkg::DIGIT_W-1:0]        digit;

  assign up_stall = dn_valid & dn_stall;
  assign load     = ~up_stall;

  // divide by ten through the reciprocal, then take the remainder
  assign prod   = pzb_pkg::PROD_W'(up_bus.rest) * pzb_pkg::PROD_W'(pzb_pkg::DIV10_MUL);
  assign quot   = pzb_pkg::ZIP_W'(prod >> pzb_pkg::DIV10_SHIFT);
  assign quot10 = (quot << 3) + (quot << 1);
  assign low    = up_bus.rest - quot10;
  assign digit  = low[pzb_pkg::DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (load) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      dn_bus.rest   <= quot;
      dn_bus.digits <= {digit, up_bus.digits[pzb_pkg::DIGITS_W-1:pzb_pkg::DIGIT_W]};
      dn_bus.sum    <= up_bus.sum + pzb_pkg::SUM_W'(digit);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pzb_encode_stage.sv =====
// Final stage: form the check digit and frame the bar groups into the 32-bar word.
`timescale 1ns / 1ps
`default_nettype none
module pzb_encode_stage (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        up_valid,
  output logic                             up_stall,
  input  wire pzb_pkg::digit_bus_t         up_bus,
  output logic                             dn_valid,
  input  wire logic                        dn_stall,
  output logic [pzb_pkg::BAR_W-1:0]        bars,
  output logic [pzb_pkg::CHECK_W-1:0]      check
);

  logic                          load;
  logic [pzb_pkg::CHECK_W-1:0]   check_next;
  logic [pzb_pkg::BAR_W-1:0]     bars_next;

  assign up_stall = dn_valid & dn_stall;
  assign load     = ~up_stall;

  assign check_next = pzb_pkg::check_of(up_bus.sum);
  assign bars_next  = {1'b1,
                       pzb_pkg::group_of(up_bus.digits[19:16]),
                       pzb_pkg::group_of(up_bus.digits[15:12]),
                       pzb_pkg::group_of(up_bus.digits[11:8]),
                       pzb_pkg::group_of(up_bus.digits[7:4]),
                       pzb_pkg::group_of(up_bus.digits[3:0]),
                       pzb_pkg::group_of(check_next),
                       1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (load) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      bars  <= bars_next;
      check <= check_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/postnet_zip_barcode_encoder_unit.sv =====
// An accepted ZIP word passes reduce, five digit stages and encode on its way to the bar word.
// One word per cycle while the output is not stalled; each stage holds one word and frees
// as soon as its successor takes it, so bubbles are squeezed out while the output is stalled.
// in_stall rises only when all seven stages are full and the output word is stalled.
// Reset: synchronous, active high; clears every stage valid bit, payload registers keep junk.
`timescale 1ns / 1ps
`default_nettype none
module postnet_zip_barcode_encoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pzb_pkg::ZIP_W-1:0]     zip_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pzb_pkg::BAR_W-1:0]          bar_pattern,
  output logic [pzb_pkg::CHECK_W-1:0]        check_value
);

  // Stage k hands to stage k+1 over valid[k] / stall[k] and bus[k].
  // Index 0 is the reduce stage output, 1..5 the digit stage outputs.
  logic                valid [pzb_pkg::NDIGITS+1];
  logic                stall [pzb_pkg::NDIGITS+1];
  pzb_pkg::digit_bus_t bus   [pzb_pkg::NDIGITS+1];

  // Fold values above 99999 back into range; only the low five decimals get encoded.
  pzb_reduce_stage u_reduce (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .zip_in   (zip_value),
    .dn_valid (valid[0]),
    .dn_stall (stall[0]),
    .dn_bus   (bus[0])
  );

  // One decimal digit per stage, least significant first; each stage also
  // accumulates the running digit sum for the check digit.
  for (genvar k = 0; k < pzb_pkg::NDIGITS; k++) begin : g_digit
    pzb_digit_stage u_digit (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid[k]),
      .up_stall (stall[k]),
      .up_bus   (bus[k]),
      .dn_valid (valid[k+1]),
      .dn_stall (stall[k+1]),
      .dn_bus   (bus[k+1])
    );
  end

  // Check digit plus framing; this register is the output word.
  pzb_encode_stage u_encode (
    .clk      (clk),
    .rst      (rst),
    .up_valid (valid[pzb_pkg::NDIGITS]),
    .up_stall (stall[pzb_pkg::NDIGITS]),
    .up_bus   (bus[pzb_pkg::NDIGITS]),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .bars     (bar_pattern),
    .check    (check_value)
  );

endmodule
`default_nettype wire

// ===== rtl/core/pzb_checker.sv =====
// Port-level checker for the POSTNET encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pzb_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [pzb_pkg::ZIP_W-1:0]     zip_value,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [pzb_pkg::BAR_W-1:0]     bar_pattern,
  input wire logic [pzb_pkg::CHECK_W-1:0]   check_value
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bar_pattern) && $stable(check_value))
    else $error("stalled output word changed");

  // input backs up only when the output word is valid and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipe");

  // frame bars, and twelve full bars across the six groups
  a_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bar_pattern[31] && bar_pattern[0] && $countones(bar_pattern[30:1]) == 12)
    else $error("malformed bar word");

  // check group matches the reported check digit
  a_check_group: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> check_value <= 4'd9 && bar_pattern[5:1] == pzb_pkg::group_of(check_value))
    else $error("check group disagrees with check digit");

  // drop all words on reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind postnet_zip_barcode_encoder_unit pzb_checker u_pzb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .zip_value   (zip_value),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .bar_pattern (bar_pattern),
  .check_value (check_value)
);
`default_nettype wire
